// File: src/edfq_pkg.sv
// Shared types, constants and codes for the EDF quantum task scheduler.
// No dependencies; every other file in src imports this package.
package edfq_pkg;

   localparam int MAX_TASKS  = 16;
   localparam int SLOT_W     = $clog2(MAX_TASKS);
   localparam int CNT_W      = $clog2(MAX_TASKS + 1);
   localparam int BURST_W    = 16;
   localparam int DL_W       = 32;
   localparam int TIME_W     = 32;
   localparam int Q_W        = 16;
   localparam int SLOT_OUT_W = 4;
   localparam int MASK_W     = 16;

   localparam logic [Q_W-1:0] QUANTUM_RESET = 16'd10;

   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   typedef enum logic [1:0] {
      KIND_ADDED = 2'd0,
      KIND_FULL  = 2'd1,
      KIND_RAN   = 2'd2,
      KIND_IDLE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic              action;
      logic [BURST_W-1:0] burst;
      logic [DL_W-1:0]    deadline;
   } req_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [SLOT_OUT_W-1:0] slot;
      logic [BURST_W-1:0]    slice;
      logic                  task_done;
      logic [MASK_W-1:0]     discarded_mask;
      logic [TIME_W-1:0]     time_now;
   } rsp_type;

   // Write, set and clear requests toward the task table.
   typedef struct packed {
      logic               burst_we;
      logic               dl_we;
      logic [SLOT_W-1:0]  wr_slot;
      logic [BURST_W-1:0] burst;
      logic [DL_W-1:0]    deadline;
      logic               set_valid;
      logic               clr_valid;
      logic [SLOT_W-1:0]  clr_slot;
      logic [SLOT_W-1:0]  rd_slot;
   } tbl_cmd_type;

   typedef struct packed {
      logic              clr;
      logic              eval_on;
      logic [SLOT_W-1:0] eval_slot;
   } scan_cmd_type;

   typedef struct packed {
      logic                 found;
      logic [SLOT_W-1:0]    slot;
      logic [BURST_W-1:0]   burst;
      logic [DL_W-1:0]      deadline;
      logic [MAX_TASKS-1:0] mask;
   } scan_res_type;

endpackage

// File: src/edfq_table.sv
// Task table: burst and deadline memories with one registered read port,
// plus per-slot valid flops. Depends on edfq_pkg.
module edfq_table
   import edfq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  tbl_cmd_type          cmd,
   output logic [BURST_W-1:0]   rd_burst,
   output logic [DL_W-1:0]      rd_deadline,
   output logic [MAX_TASKS-1:0] valid
);

   logic [BURST_W-1:0]   burst_mem [MAX_TASKS];
   logic [DL_W-1:0]      dl_mem    [MAX_TASKS];
   logic [BURST_W-1:0]   rd_burst_ff;
   logic [DL_W-1:0]      rd_dl_ff;
   logic [MAX_TASKS-1:0] valid_ff;
   logic [MAX_TASKS-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (cmd.burst_we) begin
         burst_mem[cmd.wr_slot] <= cmd.burst;
      end
      if (cmd.dl_we) begin
         dl_mem[cmd.wr_slot] <= cmd.deadline;
      end
      rd_burst_ff <= burst_mem[cmd.rd_slot];
      rd_dl_ff    <= dl_mem[cmd.rd_slot];
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.set_valid) begin
         valid_in[cmd.wr_slot] = 1'b1;
      end
      if (cmd.clr_valid) begin
         valid_in[cmd.clr_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_burst    = rd_burst_ff;
   assign rd_deadline = rd_dl_ff;
   assign valid       = valid_ff;

endmodule

// File: src/edfq_scan.sv
// Scan unit: judges one table entry per cycle, drops late tasks and keeps
// the earliest-deadline runnable candidate. Depends on edfq_pkg.
module edfq_scan
   import edfq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  scan_cmd_type         cmd,
   input  logic [MAX_TASKS-1:0] valid,
   input  logic [BURST_W-1:0]   rd_burst,
   input  logic [DL_W-1:0]      rd_deadline,
   input  logic [TIME_W-1:0]    time_now,
   output logic                 drop,
   output scan_res_type         res
);

   logic                 found_ff, found_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [BURST_W-1:0]   burst_ff, burst_in;
   logic [DL_W-1:0]      dl_ff, dl_in;
   logic [MAX_TASKS-1:0] mask_ff, mask_in;
   logic                 vbit;
   logic                 late;
   logic                 take;

   always_comb begin
      vbit = valid[cmd.eval_slot];
      late = rd_deadline < time_now;
      drop = cmd.eval_on && vbit && late;
      // strict compare keeps the lowest slot on equal deadlines
      take = cmd.eval_on && vbit && !late && (rd_burst != '0) &&
             (!found_ff || (rd_deadline < dl_ff));
   end

   always_comb begin
      found_in = found_ff;
      slot_in  = slot_ff;
      burst_in = burst_ff;
      dl_in    = dl_ff;
      mask_in  = mask_ff;
      if (cmd.clr) begin
         found_in = 1'b0;
         mask_in  = '0;
      end else begin
         if (drop) begin
            mask_in[cmd.eval_slot] = 1'b1;
         end
         if (take) begin
            found_in = 1'b1;
            slot_in  = cmd.eval_slot;
            burst_in = rd_burst;
            dl_in    = rd_deadline;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         mask_ff  <= '0;
      end else begin
         found_ff <= found_in;
         mask_ff  <= mask_in;
      end
      slot_ff  <= slot_in;
      burst_ff <= burst_in;
      dl_ff    <= dl_in;
   end

   assign res.found    = found_ff;
   assign res.slot     = slot_ff;
   assign res.burst    = burst_ff;
   assign res.deadline = dl_ff;
   assign res.mask     = mask_ff;

endmodule

// File: src/edf_quantum_task_scheduler_core.sv
// Top level of the EDF quantum task scheduler: sequencer, slice and time
// update, output register. Depends on edfq_pkg, edfq_table and edfq_scan.

// Earliest-deadline-first scheduler over a table of MAX_TASKS slots. Each
// request word is either an add (action 0) or a scheduling step (action 1),
// and each produces exactly one response word. An add is accepted in the
// idle state, then places the task in the lowest free slot (or reports
// the table full) once the output register is free. In a step the task
// table has a single registered read port, so the scan unit walks the
// table one slot per cycle, dropping every task whose deadline is before
// the current time and tracking the earliest runnable deadline (lowest
// slot on ties); the decide state then grants min(burst, quantum), writes
// back the burst, frees a finished slot and advances the saturating
// time. req_ready is high only while the sequencer
// is idle. The response sits in an output register, so the next request
// word is taken while the previous response waits; a finished item holds
// in its last state only while that register is still full. The quantum
// register (reset 10) is written through the csr channel, which is always
// ready; write it only while the block is idle.
module edf_quantum_task_scheduler_core
   import edfq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [Q_W-1:0] csr_data
);

   // sequencer state
   state_type state_ff, state_in;

   // held request word
   req_type req_ff, req_in;

   // scan issue pipeline: read address counter, then the slot being judged
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              eval_on_ff, eval_on_in;
   logic [SLOT_W-1:0] eval_slot_ff, eval_slot_in;

   logic [TIME_W-1:0] time_ff, time_in;
   logic [Q_W-1:0]    quantum_ff, quantum_in;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // table and scan unit hookup
   tbl_cmd_type          tbl_cmd;
   scan_cmd_type         scan_cmd;
   scan_res_type         scan_res;
   logic [BURST_W-1:0]   rd_burst;
   logic [DL_W-1:0]      rd_deadline;
   logic [MAX_TASKS-1:0] valid;
   logic                 drop;

   logic              req_accept;
   logic              out_free;
   logic              rsp_load;
   logic              issue;
   logic              free_found;
   logic [SLOT_W-1:0] free_slot;
   logic [BURST_W-1:0] slice;
   logic [BURST_W-1:0] burst_left;
   logic [TIME_W:0]    time_sum;
   logic [TIME_W-1:0]  time_next;

   edfq_table u_table (
      .clock       (clock),
      .reset       (reset),
      .cmd         (tbl_cmd),
      .rd_burst    (rd_burst),
      .rd_deadline (rd_deadline),
      .valid       (valid)
   );

   edfq_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .cmd         (scan_cmd),
      .valid       (valid),
      .rd_burst    (rd_burst),
      .rd_deadline (rd_deadline),
      .time_now    (time_ff),
      .drop        (drop),
      .res         (scan_res)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign issue      = (cnt_ff != CNT_W'(MAX_TASKS));
   assign csr_ready  = 1'b1;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (!valid[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   // slice grant and saturating time advance
   always_comb begin
      slice      = (scan_res.burst > quantum_ff) ? quantum_ff : scan_res.burst;
      burst_left = scan_res.burst - slice;
      time_sum   = {1'b0, time_ff} + (TIME_W + 1)'(slice);
      time_next  = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_data.action == ACT_ADD) ? ST_ADD : ST_SCAN;
            end
         end
         ST_ADD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!issue) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      eval_on_in   = 1'b0;
      eval_slot_in = eval_slot_ff;
      time_in      = time_ff;
      rsp_in       = rsp_ff;
      rsp_load     = 1'b0;

      tbl_cmd           = '0;
      tbl_cmd.rd_slot   = cnt_ff[SLOT_W-1:0];
      tbl_cmd.clr_slot  = eval_slot_ff;
      scan_cmd.clr       = 1'b0;
      scan_cmd.eval_on   = eval_on_ff;
      scan_cmd.eval_slot = eval_slot_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in       = req_data;
               cnt_in       = '0;
               scan_cmd.clr = 1'b1;
            end
         end
         ST_ADD: begin
            if (out_free) begin
               rsp_load              = 1'b1;
               rsp_in                = '0;
               rsp_in.time_now       = time_ff;
               if (free_found) begin
                  tbl_cmd.burst_we  = 1'b1;
                  tbl_cmd.dl_we     = 1'b1;
                  tbl_cmd.set_valid = 1'b1;
                  tbl_cmd.wr_slot   = free_slot;
                  tbl_cmd.burst     = req_ff.burst;
                  tbl_cmd.deadline  = req_ff.deadline;
                  rsp_in.kind       = KIND_ADDED;
                  rsp_in.slot       = SLOT_OUT_W'(free_slot);
               end else begin
                  rsp_in.kind = KIND_FULL;
               end
            end
         end
         ST_SCAN: begin
            // issue the next read; judge the one read last cycle
            if (issue) begin
               cnt_in       = cnt_ff + CNT_W'(1);
               eval_on_in   = 1'b1;
               eval_slot_in = cnt_ff[SLOT_W-1:0];
            end
            tbl_cmd.clr_valid = drop;
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_load              = 1'b1;
               rsp_in                = '0;
               rsp_in.discarded_mask = MASK_W'(scan_res.mask);
               rsp_in.time_now       = time_ff;
               if (scan_res.found) begin
                  tbl_cmd.burst_we  = 1'b1;
                  tbl_cmd.wr_slot   = scan_res.slot;
                  tbl_cmd.burst     = burst_left;
                  tbl_cmd.clr_valid = (burst_left == '0);
                  tbl_cmd.clr_slot  = scan_res.slot;
                  time_in           = time_next;
                  rsp_in.kind       = KIND_RAN;
                  rsp_in.slot       = SLOT_OUT_W'(scan_res.slot);
                  rsp_in.slice      = slice;
                  rsp_in.task_done  = (burst_left == '0);
                  rsp_in.time_now   = time_next;
               end else begin
                  rsp_in.kind = KIND_IDLE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // output register: load a finished word, drop it once taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign quantum_in = (csr_valid && csr_ready) ? csr_data : quantum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         eval_on_ff   <= 1'b0;
         time_ff      <= '0;
         quantum_ff   <= QUANTUM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         eval_on_ff   <= eval_on_in;
         time_ff      <= time_in;
         quantum_ff   <= quantum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      eval_slot_ff <= eval_slot_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
